### rtl/fatlb_pkg.sv
// fatlb_pkg: shared constants, command codes and control types for the translation buffer
// used by fatlb_ctrl, fatlb_dp and fully_associative_tlb
`timescale 1ns / 1ps
`default_nettype none
package fatlb_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int ADDR_W      = 64;
	localparam int PAGE_SHIFT  = 12;
	localparam int TAG_W       = ADDR_W - PAGE_SHIFT;
	localparam int WORD_W      = 52;
	localparam int FLAGS_W     = 10;
	localparam int CNT_W       = 32;

	typedef enum logic [1:0] {
		CMD_LOOKUP    = 2'd0,
		CMD_INSERT    = 2'd1,
		CMD_INVAL_ONE = 2'd2,
		CMD_INVAL_ALL = 2'd3
	} cmd_t;

	typedef struct packed {
		logic load;
		logic match;
		logic apply;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

### rtl/fatlb_ctrl.sv
// fatlb_ctrl: sequencer for one word: capture, tag compare and update; fatlb_dp reports the result
// depends on fatlb_pkg
`timescale 1ns / 1ps
`default_nettype none
module fatlb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output fatlb_pkg::ctrl_cmd_t   cmd
);
	import fatlb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_APPLY
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_MATCH;
				end
				ST_MATCH: state_q <= ST_APPLY;
				ST_APPLY: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cmd.load  = (state_q == ST_IDLE) && start;
	assign cmd.match = (state_q == ST_MATCH);
	assign cmd.apply = (state_q == ST_APPLY);

	a_match_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.match) else $error("compare step did not follow capture");
	a_apply_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match |=> cmd.apply) else $error("update step did not follow compare");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.match, cmd.apply})) else $error("overlapping steps");

endmodule
`default_nettype wire

### rtl/fatlb_dp.sv
// fatlb_dp: entry array, parallel tag compare, first-match and first-free select, counters
// depends on fatlb_pkg, driven by fatlb_ctrl
`timescale 1ns / 1ps
`default_nettype none
module fatlb_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fatlb_pkg::ctrl_cmd_t            cmd,
	input  wire logic [1:0]                      command,
	input  wire logic [fatlb_pkg::ADDR_W-1:0]    virtual_addr,
	input  wire logic [fatlb_pkg::ADDR_W-1:0]    physical_addr,
	input  wire logic [fatlb_pkg::FLAGS_W-1:0]   page_flags,
	output logic                                 done,
	output logic                                 hit,
	output logic [fatlb_pkg::WORD_W-1:0]         entry_word,
	output logic                                 evicted,
	output logic [fatlb_pkg::CNT_W-1:0]          hit_count,
	output logic [fatlb_pkg::CNT_W-1:0]          miss_count,
	output logic [fatlb_pkg::CNT_W-1:0]          eviction_count
);
	import fatlb_pkg::*;

	cmd_t                   cmd_s1;
	logic [TAG_W-1:0]       tag_s1;
	logic [WORD_W-1:0]      word_s1;
	logic [NUM_ENTRIES-1:0] match_s2;

	logic [NUM_ENTRIES-1:0] valid_q;
	logic [TAG_W-1:0]       tags_q  [NUM_ENTRIES];
	logic [WORD_W-1:0]      words_q [NUM_ENTRIES];
	logic [CNT_W-1:0]       hits_q, misses_q, evicts_q;

	logic                   done_q, hit_q, evicted_q;
	logic [WORD_W-1:0]      entry_word_q;

	logic [IDX_W-1:0]       match_idx, free_idx, ins_idx;
	logic                   found, full;

	// lowest index wins for both selects
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			if (match_s2[i]) match_idx = IDX_W'(i);
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end

	assign found   = |match_s2;
	assign full    = &valid_q;
	assign ins_idx = full ? '0 : free_idx;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_s1  <= cmd_t'(command);
			tag_s1  <= virtual_addr[ADDR_W-1:PAGE_SHIFT];
			word_s1 <= WORD_W'(physical_addr[ADDR_W-1:PAGE_SHIFT]) | WORD_W'(page_flags);
		end
		if (cmd.match) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				match_s2[i] <= valid_q[i] && (tags_q[i] == tag_s1);
			end
		end
		if (cmd.apply && (cmd_s1 == CMD_INSERT)) begin
			tags_q[ins_idx]  <= tag_s1;
			words_q[ins_idx] <= word_s1;
		end
		if (cmd.apply) begin
			entry_word_q <= ((cmd_s1 == CMD_LOOKUP) && found) ? words_q[match_idx] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			evicts_q  <= '0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			evicted_q <= 1'b0;
		end else begin
			done_q <= cmd.apply;
			if (cmd.apply) begin
				hit_q     <= 1'b0;
				evicted_q <= 1'b0;
				case (cmd_s1)
					CMD_LOOKUP: begin
						if (found) begin
							hit_q  <= 1'b1;
							hits_q <= hits_q + 1'b1;
						end else begin
							misses_q <= misses_q + 1'b1;
						end
					end
					CMD_INSERT: begin
						valid_q[ins_idx] <= 1'b1;
						if (full) begin
							evicted_q <= 1'b1;
							evicts_q  <= evicts_q + 1'b1;
						end
					end
					CMD_INVAL_ONE: begin
						if (found) valid_q[match_idx] <= 1'b0;
					end
					CMD_INVAL_ALL: valid_q <= '0;
					default: valid_q <= valid_q;
				endcase
			end
		end
	end

	assign done           = done_q;
	assign hit            = hit_q;
	assign entry_word     = entry_word_q;
	assign evicted        = evicted_q;
	assign hit_count      = hits_q;
	assign miss_count     = misses_q;
	assign eviction_count = evicts_q;

	a_done_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.apply)) else $error("result strobe without update step");
	a_hit_not_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && hit_q) |-> !evicted_q) else $error("hit and eviction in one result");
	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && evicted_q) |-> $past(full)) else $error("eviction with a free entry");
	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({hits_q != $past(hits_q), misses_q != $past(misses_q),
			evicts_q != $past(evicts_q)}) <= 1) else $error("two counters moved at once");

endmodule
`default_nettype wire

### rtl/fully_associative_tlb.sv
// fully_associative_tlb: top level of the translation buffer
// depends on fatlb_pkg, fatlb_ctrl and fatlb_dp
`timescale 1ns / 1ps
`default_nettype none
// A command word is taken when start is high and busy is low. The sequencer steps each
// word through capture, parallel compare of all tags, then update. busy drops in the
// cycle the result appears, so a new word can be taken in that cycle, not before.
// The result is valid while done is high, for exactly one cycle; there is no
// way to hold it, so the receiver must take it then. Counters wrap at 32 bits.
module fully_associative_tlb (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      command,
	input  wire logic [fatlb_pkg::ADDR_W-1:0]    virtual_addr,
	input  wire logic [fatlb_pkg::ADDR_W-1:0]    physical_addr,
	input  wire logic [fatlb_pkg::FLAGS_W-1:0]   page_flags,
	output logic                                 done,
	output logic                                 hit,
	output logic [fatlb_pkg::WORD_W-1:0]         entry_word,
	output logic                                 evicted,
	output logic [fatlb_pkg::CNT_W-1:0]          hit_count,
	output logic [fatlb_pkg::CNT_W-1:0]          miss_count,
	output logic [fatlb_pkg::CNT_W-1:0]          eviction_count
);
	import fatlb_pkg::*;

	ctrl_cmd_t cmd;

	fatlb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	fatlb_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.command        (command),
		.virtual_addr   (virtual_addr),
		.physical_addr  (physical_addr),
		.page_flags     (page_flags),
		.done           (done),
		.hit            (hit),
		.entry_word     (entry_word),
		.evicted        (evicted),
		.hit_count      (hit_count),
		.miss_count     (miss_count),
		.eviction_count (eviction_count)
	);

endmodule
`default_nettype wire
